FILE: design/sitd_pkg.sv
package sitd_pkg;

    localparam int DIGITS = 10;
    localparam int POS_W = $clog2(DIGITS);
    localparam int MAG_W = 32;
    localparam int WIDE_W = MAG_W + 2;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    localparam logic [WIDE_W-1:0] PLACE_TABLE [DIGITS] = '{
        34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
        34'd10000, 34'd1000, 34'd100, 34'd10, 34'd1
    };

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: design/sitd_front.sv
module sitd_front (
    input  logic                    start,
    input  logic [31:0]             value,
    input  sitd_pkg::q_status_t     q_status,
    output logic                    busy,
    output logic                    push,
    output sitd_pkg::entry_t        push_entry
);

    always_comb
    begin
        busy = q_status.full;
        push = start && !q_status.full;
        push_entry.neg = value[31];
        push_entry.mag = value[31] ? (32'd0 - value) : value;
    end

endmodule

FILE: design/sitd_queue.sv
module sitd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sitd_pkg::entry_t        push_entry,
    input  logic                    pop,
    output sitd_pkg::entry_t        pop_entry,
    output sitd_pkg::q_status_t     q_status
);

    sitd_pkg::entry_t                   mem_reg [sitd_pkg::QDEPTH];
    logic [sitd_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [sitd_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [sitd_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [sitd_pkg::QPTR_W-1:0] PTR_LAST = sitd_pkg::QPTR_W'(sitd_pkg::QDEPTH - 1);
    localparam logic [sitd_pkg::QCNT_W-1:0] CNT_FULL = sitd_pkg::QCNT_W'(sitd_pkg::QDEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        q_status.full = (count_reg == CNT_FULL);
        q_status.empty = (count_reg == '0);
        pop_entry = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/sitd_back.sv
module sitd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sitd_pkg::q_status_t q_status,
    input  sitd_pkg::entry_t    pop_entry,
    output logic                pop,
    output logic                strobe,
    output logic [7:0]          character,
    output logic                last
);

    localparam logic [sitd_pkg::POS_W-1:0] POS_LAST = sitd_pkg::POS_W'(sitd_pkg::DIGITS - 1);

    logic                               active_reg, active_next;
    logic                               sign_reg, sign_next;
    logic                               started_reg, started_next;
    logic [sitd_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [sitd_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic                               strobe_reg, strobe_next;
    logic [7:0]                         char_reg, char_next;
    logic                               last_reg, last_next;

    logic [sitd_pkg::WIDE_W-1:0]        place;
    logic [sitd_pkg::WIDE_W-1:0]        sub;
    logic [3:0]                         digit;
    logic                               finishing;
    logic                               emit;

    // digit = largest k with mag >= k * place
    always_comb
    begin
        place = sitd_pkg::PLACE_TABLE[pos_reg];
        digit = 4'd0;
        sub = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({2'b00, mag_reg} >= sitd_pkg::WIDE_W'(k) * place)
            begin
                digit = 4'(k);
                sub = sitd_pkg::WIDE_W'(k) * place;
            end
        end
    end

    always_comb
    begin
        finishing = active_reg && !sign_reg && (pos_reg == POS_LAST);
        pop = !q_status.empty && (!active_reg || finishing);
        emit = (digit != 4'd0) || started_reg || (pos_reg == POS_LAST);

        active_next = active_reg;
        sign_next = sign_reg;
        started_next = started_reg;
        pos_next = pos_reg;
        mag_next = mag_reg;
        strobe_next = 1'b0;
        char_next = char_reg;
        last_next = 1'b0;

        if (active_reg)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
                strobe_next = 1'b1;
                char_next = sitd_pkg::CHAR_MINUS;
            end
            else
            begin
                mag_next = mag_reg - sub[sitd_pkg::MAG_W-1:0];
                pos_next = pos_reg + 1'b1;
                strobe_next = emit;
                started_next = started_reg || emit;
                char_next = sitd_pkg::CHAR_ZERO + {4'd0, digit};
                last_next = (pos_reg == POS_LAST);
                if (finishing)
                begin
                    active_next = 1'b0;
                end
            end
        end

        if (pop)
        begin
            active_next = 1'b1;
            sign_next = pop_entry.neg;
            started_next = 1'b0;
            pos_next = '0;
            mag_next = pop_entry.mag;
        end

        strobe = strobe_reg;
        character = char_reg;
        last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sign_reg <= 1'b0;
            started_reg <= 1'b0;
            pos_reg <= '0;
            strobe_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            sign_reg <= sign_next;
            started_reg <= started_next;
            pos_reg <= pos_next;
            strobe_reg <= strobe_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        char_reg <= char_next;
    end

endmodule

FILE: design/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII text.
// Input: a word is taken on value at a rising edge where start is high and
// busy is low. Output: one character per cycle on character, marked by
// strobe, except where a leading zero is skipped; last is high on the final
// character of the number. The receiver cannot stall; every strobed
// character must be taken that cycle. A negative value gives '-' first;
// leading zeros are dropped; zero gives '0'.
// With the back end idle, an accepted word goes from the queue straight
// into the back end, whose characters are registered before they reach the
// outputs. The back end resolves one decimal place per cycle, skipped
// leading zeros included, and pops the next word as it finishes the last
// place. A 2-word queue sits between the input and the back end, so a
// new word is taken while the previous one is still being printed; busy is
// high only while that queue is full.
// Reset clears the queue and the converter; no characters follow reset until
// a new word is accepted.
module signed_int_to_decimal_ascii_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    output logic        busy,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last
);

    sitd_pkg::q_status_t q_status;
    sitd_pkg::entry_t    push_entry;
    sitd_pkg::entry_t    pop_entry;
    logic                push;
    logic                pop;

    sitd_front u_front (
        .start      (start),
        .value      (value),
        .q_status   (q_status),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    sitd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    sitd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .strobe     (strobe),
        .character  (character),
        .last       (last)
    );

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (character >= sitd_pkg::CHAR_ZERO &&
                              character <= sitd_pkg::CHAR_NINE))
        else $error("final character is not a digit");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == sitd_pkg::CHAR_MINUS) |-> !last)
        else $error("sign emitted as final character");

    a_minus_not_repeated: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == sitd_pkg::CHAR_MINUS) |=>
            (!strobe || character != sitd_pkg::CHAR_MINUS))
        else $error("sign emitted twice in a row");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int DIR_N = 21;
    localparam int RANDOM_WORDS = 440;
    localparam int CALM_TAIL = 80;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] value = 32'd0;
    logic        busy;
    logic        strobe;
    logic [7:0]  character;
    logic        last;

    text_char_t pending_text [$];
    int errors = 0;
    int cycle_count = 0;

    // Directed words; an empty string means the text comes from the predictor.
    logic [31:0] dir_value [DIR_N] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'd5, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'd1000000000, -32'sd1000000000, 32'd999999999, -32'sd999999999,
        32'd1234567890, -32'sd1234567890, 32'h8000_0001, 32'h7FFF_FFFE,
        32'h5555_5555, 32'hAAAA_AAAA
    };
    string dir_text [DIR_N] = '{
        "0", "1", "-1", "2147483647", "-2147483648",
        "5", "", "", "", "", "",
        "1000000000", "-1000000000", "", "",
        "", "", "", "",
        "", ""
    };

    signed_int_to_decimal_ascii_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    always #6 clk = ~clk;

    function automatic void queue_decimal_text(input logic [31:0] word);
        logic [31:0] mag;
        logic [31:0] place;
        logic [31:0] digit;
        bit started;
        started = 1'b0;
        mag = word[31] ? (32'd0 - word) : word;
        place = 32'd1000000000;
        if (word[31])
            pending_text.push_back('{sitd_pkg::CHAR_MINUS, 1'b0});
        for (int i = 0; i < sitd_pkg::DIGITS; i++)
        begin
            digit = mag / place;
            mag = mag % place;
            if (digit != 0 || started || i == sitd_pkg::DIGITS - 1)
            begin
                started = 1'b1;
                pending_text.push_back('{sitd_pkg::CHAR_ZERO + digit[7:0],
                                         i == sitd_pkg::DIGITS - 1});
            end
            place = place / 10;
        end
    endfunction

    task automatic send_word(input logic [31:0] word, input string typed);
        start <= 1'b1;
        value <= word;
        do
            @(posedge clk);
        while (busy);
        if (typed.len() == 0)
            queue_decimal_text(word);
        else
            for (int i = 0; i < typed.len(); i++)
                pending_text.push_back('{typed[i], i == typed.len() - 1});
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            value <= $urandom;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] word;
        logic [31:0] power;
        power = 32'd1;
        case ($urandom_range(0, 3))
            0: word = $urandom;
            1: word = $urandom >> $urandom_range(0, 31);
            2:
            begin
                repeat ($urandom_range(0, 9)) power = power * 10;
                word = power + $urandom_range(0, 2) - 1;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: word = 32'h8000_0000 + $urandom_range(0, 15);
                    1: word = 32'h7FFF_FFFF - $urandom_range(0, 15);
                    default: word = $urandom_range(0, 15);
                endcase
            end
        endcase
        if ($urandom_range(0, 1))
            word = 32'd0 - word;
        return word;
    endfunction

    // every strobed character is checked against the oldest expected one
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (pending_text.size() == 0)
            begin
                $error("character: expected none, got %0d (last %0b)", character, last);
                errors++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (character !== want.ch)
                begin
                    $error("character: expected %0d, got %0d", want.ch, character);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            maybe_idle(1'b1);
            send_word(dir_value[i], dir_text[i]);
        end

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            maybe_idle(k < RANDOM_WORDS - CALM_TAIL);
            send_word(random_word(), "");
        end
        start <= 1'b0;

        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (errors == 0 && pending_text.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
